### rtl/kmp_stream_matcher_top_defines.svh
// Assertion macros for the matcher top level.
`ifndef KMP_STREAM_MATCHER_TOP_DEFINES_SVH
`define KMP_STREAM_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define KSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define KSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/kmp_pkg.sv
package kmp_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int POS_W           = 32;
  localparam int SYM_W           = 8;
  localparam int MODE_W          = 2;

  localparam logic [MODE_W-1:0] MODE_CLR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TXT = 2'd2;

  typedef enum logic [1:0] {
    OP_CLR,
    OP_APP,
    OP_TXT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] sym;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APP,
    ST_TXT
  } bstate_t;

  typedef struct packed {
    logic busy;
    logic txt_busy;
    logic empty;
  } bsts_t;

endpackage

### rtl/kmp_ram.sv
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/kmp_front.sv
module kmp_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [kmp_pkg::MODE_W-1:0] in_mode,
  input  logic [kmp_pkg::SYM_W-1:0]  in_symbol,
  output logic                      q_valid,
  output kmp_pkg::item_t            q_item,
  input  logic                      q_pop
);

  import kmp_pkg::*;

  item_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        known;
  logic        push;
  item_t       item_in;

  always_comb begin
    item_in.sym = in_symbol;
    known       = 1'b1;
    unique case (in_mode)
      MODE_CLR: item_in.op = OP_CLR;
      MODE_APP: item_in.op = OP_APP;
      MODE_TXT: item_in.op = OP_TXT;
      default: begin
        item_in.op = OP_CLR;
        known      = 1'b0;
      end
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready && known;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

### rtl/kmp_back.sv
module kmp_back #(
  parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  kmp_pkg::item_t            q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [kmp_pkg::POS_W-1:0] out_match_start,
  output kmp_pkg::bsts_t            sts
);

  import kmp_pkg::*;

  localparam int IW = $clog2(MAX_PATTERN);
  localparam logic [IW:0]        MAXL = (IW+1)'(MAX_PATTERN);
  localparam logic signed [IW:0] ONE  = (IW+1)'(1);
  localparam logic signed [IW:0] NEG1 = '1;

  bstate_t                 state_r, state_nxt;
  logic [IW:0]             len_r, len_nxt;
  logic signed [IW:0]      bp_r, bp_nxt;
  logic [IW-1:0]           mi_r, mi_nxt;
  logic signed [IW:0]      j_r, j_nxt;
  logic [POS_W-1:0]        tp_r, tp_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [SYM_W-1:0]        key_r, key_nxt;
  logic [SYM_W-1:0]        sym_r, sym_nxt;
  logic [SYM_W-1:0]        prev_r, prev_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]        out_data_r, out_data_nxt;

  logic                    rd_en;
  logic [IW-1:0]           rd_addr;
  logic                    p_we;
  logic                    f_we;
  logic [IW-1:0]           f_wdata;
  logic [SYM_W-1:0]        p_wdata;
  logic [SYM_W-1:0]        p_rd;
  logic [IW-1:0]           f_rd;

  logic signed [IW:0]      fail_val;
  logic signed [IW:0]      j_inc;
  logic                    hit;
  logic                    last;
  logic                    out_free;
  logic                    len_zero;
  logic                    len_full;

  kmp_ram #(.WIDTH(SYM_W), .DEPTH(MAX_PATTERN)) u_pat (
    .clk   (clk),
    .we    (p_we),
    .waddr (len_r[IW-1:0]),
    .wdata (p_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (p_rd)
  );

  kmp_ram #(.WIDTH(IW), .DEPTH(MAX_PATTERN)) u_fail (
    .clk   (clk),
    .we    (f_we),
    .waddr (len_r[IW-1:0]),
    .wdata (f_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (f_rd)
  );

  assign len_zero = (len_r == '0);
  assign len_full = (len_r == MAXL);
  assign fail_val = (j_r == '0) ? NEG1 : $signed({1'b0, f_rd});
  assign j_inc    = j_r + ONE;
  assign hit      = j_r[IW] || (key_r == p_rd);
  assign last     = (j_r == $signed(len_r - 1'b1));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            OP_APP: if (!len_zero && !len_full) state_nxt = ST_APP;
            OP_TXT: if (!len_zero) state_nxt = ST_TXT;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_APP: if (hit) state_nxt = ST_IDLE;
      ST_TXT: if (hit && !last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    len_nxt       = len_r;
    bp_nxt        = bp_r;
    mi_nxt        = mi_r;
    j_nxt         = j_r;
    tp_nxt        = tp_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    sym_nxt       = sym_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = j_r[IW-1:0];
    p_we          = 1'b0;
    f_we          = 1'b0;
    p_wdata       = sym_r;
    f_wdata       = j_inc[IW-1:0];
    q_pop         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_CLR: begin
              len_nxt = '0;
              bp_nxt  = NEG1;
              mi_nxt  = '0;
              tp_nxt  = '0;
            end
            OP_APP: begin
              if (len_zero) begin
                p_we     = 1'b1;
                p_wdata  = q_item.sym;
                len_nxt  = ONE;
                bp_nxt   = NEG1;
                mi_nxt   = '0;
                tp_nxt   = '0;
                prev_nxt = q_item.sym;
              end else if (!len_full) begin
                j_nxt   = bp_r;
                rd_en   = 1'b1;
                rd_addr = bp_r[IW-1:0];
                sym_nxt = q_item.sym;
                key_nxt = prev_r;
              end
            end
            OP_TXT: begin
              tp_nxt = tp_r + 1'b1;
              if (!len_zero) begin
                pos_nxt = tp_r;
                j_nxt   = $signed({1'b0, mi_r});
                rd_en   = 1'b1;
                rd_addr = mi_r;
                key_nxt = q_item.sym;
              end
            end
            default: ;
          endcase
        end
      end
      ST_APP: begin
        if (hit) begin
          p_we     = 1'b1;
          f_we     = 1'b1;
          len_nxt  = len_r + 1'b1;
          bp_nxt   = j_inc;
          mi_nxt   = '0;
          tp_nxt   = '0;
          prev_nxt = sym_r;
        end else begin
          j_nxt   = fail_val;
          rd_en   = 1'b1;
          rd_addr = fail_val[IW-1:0];
        end
      end
      ST_TXT: begin
        if (hit && last) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = pos_r - {{(POS_W-IW){1'b0}}, j_r[IW-1:0]};
            j_nxt         = fail_val;
            rd_en         = 1'b1;
            rd_addr       = fail_val[IW-1:0];
          end
        end else if (hit) begin
          mi_nxt = j_inc[IW-1:0];
        end else begin
          j_nxt   = fail_val;
          rd_en   = 1'b1;
          rd_addr = fail_val[IW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      bp_r        <= NEG1;
      mi_r        <= '0;
      tp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      bp_r        <= bp_nxt;
      mi_r        <= mi_nxt;
      tp_r        <= tp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    pos_r      <= pos_nxt;
    key_r      <= key_nxt;
    sym_r      <= sym_nxt;
    prev_r     <= prev_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_match_start = out_data_r;
  assign sts.busy        = (state_r != ST_IDLE);
  assign sts.txt_busy    = (state_r == ST_TXT);
  assign sts.empty       = len_zero;

endmodule

### rtl/kmp_stream_matcher_top.sv
// A text byte waits in the input queue until the back end is idle, which pops it and issues
// its memory read; each failure link takes another read, and a full match registers a result.
// The back end takes a new item only when idle; clear, the first append and text on an empty
// pattern need no memory read, while other items share the single read port.
// Reset (rst_n low, synchronous) clears the queue, length, prefix, index, position
// and output valid; pattern and failure memories keep their contents.
`include "kmp_stream_matcher_top_defines.svh"

module kmp_stream_matcher_top #(
  parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [kmp_pkg::MODE_W-1:0] in_mode,
  input  logic [kmp_pkg::SYM_W-1:0]  in_symbol,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kmp_pkg::POS_W-1:0]  out_match_start
);

  import kmp_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;
  bsts_t bst;

  kmp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_symbol (in_symbol),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  kmp_back #(.MAX_PATTERN(MAX_PATTERN)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_start (out_match_start),
    .sts             (bst)
  );

  `KSM_ASSERT_IMPL(a_pop_idle, q_pop, q_valid && !bst.busy, "queue popped while busy")
  `KSM_ASSERT_IMPL(a_match_src, $rose(out_valid), $past(bst.txt_busy), "result without text")
  `KSM_ASSERT_NEXT(a_clear, q_pop && q_item.op == OP_CLR, bst.empty && !bst.busy, "clear failed")

endmodule

### sim/kmp_stream_matcher_top_test.sv
`timescale 1ns / 100ps

module kmp_stream_matcher_top_test;
  import kmp_pkg::*;

  localparam int                MAXP        = MAX_PATTERN_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int                STALL_LIMIT = 4000;
  localparam int                TAIL_CYCLES = 200;
  localparam int                PHASE_ITEMS = 100;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
  } stim_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [MODE_W-1:0] in_mode = MODE_CLR;
  logic [SYM_W-1:0]  in_symbol = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [POS_W-1:0]  out_match_start;

  stim_item_t       pending_items[$];
  logic [POS_W-1:0] expected_starts[$];
  int               queued_count = 0;
  int               error_count = 0;
  int               stall_cycles = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;

  logic [SYM_W-1:0] pat_bytes[MAXP];
  int               fail_link[MAXP];
  int               pat_len;
  int               build_pre;
  int               match_idx;
  logic [POS_W-1:0] text_pos;

  kmp_stream_matcher_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_symbol      (in_symbol),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_match_start(out_match_start)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_matcher();
    fail_link[0] = -1;
    pat_len      = 0;
    build_pre    = -1;
    match_idx    = 0;
    text_pos     = '0;
  endfunction

  function automatic void predict_item(logic [MODE_W-1:0] mode, logic [SYM_W-1:0] sym);
    int               t;
    int               j;
    bit               done;
    logic [SYM_W-1:0] prev;
    logic [POS_W-1:0] pos;
    case (mode)
      MODE_CLR: begin
        clear_matcher();
      end
      MODE_APP: begin
        if (pat_len < MAXP) begin
          if (pat_len == 0) begin
            fail_link[0] = -1;
            build_pre    = -1;
          end else begin
            t    = build_pre;
            prev = pat_bytes[pat_len-1];
            done = 1'b0;
            while (!done) begin
              if (t < 0 || prev == pat_bytes[t]) begin
                t++;
                fail_link[pat_len] = t;
                done = 1'b1;
              end else begin
                t = fail_link[t];
              end
            end
            build_pre = t;
          end
          pat_bytes[pat_len] = sym;
          pat_len++;
          match_idx = 0;
          text_pos  = '0;
        end
      end
      MODE_TXT: begin
        pos      = text_pos;
        text_pos = pos + 1;
        if (pat_len > 0) begin
          j    = match_idx;
          done = 1'b0;
          while (!done) begin
            if (j < 0 || sym == pat_bytes[j]) begin
              if (j == pat_len - 1) begin
                expected_starts = {expected_starts, pos - POS_W'(j)};
                j = fail_link[j];
              end else begin
                j++;
                done = 1'b1;
              end
            end else begin
              j = fail_link[j];
            end
          end
          match_idx = j;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void push_item(logic [MODE_W-1:0] mode, logic [SYM_W-1:0] sym);
    stim_item_t it;
    it.mode   = mode;
    it.symbol = sym;
    pending_items = {pending_items, it};
    if (mode != MODE_UNUSED) queued_count++;
  endfunction

  // Build a pattern over a two-letter alphabet, then search text mostly over the same letters.
  function automatic void add_search_session(bit long_pattern);
    logic [SYM_W-1:0] sym_a;
    logic [SYM_W-1:0] sym_b;
    int               plen;
    int               tlen;
    int               r;
    sym_a = SYM_W'($urandom_range(255));
    sym_b = sym_a ^ SYM_W'($urandom_range(1, 255));
    if ($urandom_range(9) != 0) push_item(MODE_CLR, SYM_W'($urandom_range(255)));
    plen = long_pattern ? $urandom_range(MAXP, MAXP + 3) : $urandom_range(1, 5);
    for (int i = 0; i < plen; i++) begin
      push_item(MODE_APP, (long_pattern || $urandom_range(1)) ? sym_a : sym_b);
    end
    tlen = long_pattern ? MAXP + 16 : $urandom_range(8, 40);
    for (int i = 0; i < tlen; i++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        push_item(MODE_UNUSED, SYM_W'($urandom_range(255)));
      end else if (r < 5 && !long_pattern) begin
        push_item(MODE_APP, $urandom_range(1) ? sym_a : sym_b);
      end else if (r < 8) begin
        push_item(MODE_TXT, SYM_W'($urandom_range(255)));
      end else if (long_pattern) begin
        push_item(MODE_TXT, (r < 11) ? sym_b : sym_a);
      end else begin
        push_item(MODE_TXT, $urandom_range(1) ? sym_a : sym_b);
      end
    end
  endfunction

  // Sender: hold the payload until transfer, idle at random between items.
  always @(posedge clk) begin
    stim_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_valid  <= 1'b1;
        in_mode   <= it.mode;
        in_symbol <= it.symbol;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    logic [POS_W-1:0] exp_start;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_starts.size() == 0) begin
          $display("%0t: unexpected match_start: expected none, actual %0d",
                   $time, out_match_start);
          error_count++;
        end else begin
          exp_start = expected_starts.pop_front();
          if (out_match_start !== exp_start) begin
            $display("%0t: match_start mismatch: expected %0d, actual %0d",
                     $time, exp_start, out_match_start);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_item(in_mode, in_symbol);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else if (pending_items.size() > 0 || in_valid || expected_starts.size() > 0) begin
        stall_cycles++;
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    clear_matcher();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pattern, unused mode, single and overlapping matches.
    push_item(MODE_TXT, 8'h41);
    push_item(MODE_UNUSED, 8'hFF);
    push_item(MODE_APP, 8'h00);
    push_item(MODE_TXT, 8'h00);
    push_item(MODE_TXT, 8'hFF);
    push_item(MODE_TXT, 8'h00);
    push_item(MODE_APP, 8'h00);
    for (int i = 0; i < 4; i++) push_item(MODE_TXT, 8'h00);
    push_item(MODE_CLR, 8'hA5);
    push_item(MODE_APP, 8'hFF);
    push_item(MODE_APP, 8'h5A);
    push_item(MODE_APP, 8'hFF);
    push_item(MODE_TXT, 8'hFF);
    push_item(MODE_TXT, 8'h5A);
    push_item(MODE_TXT, 8'hFF);
    push_item(MODE_TXT, 8'h5A);
    push_item(MODE_TXT, 8'hFF);
    push_item(MODE_UNUSED, 8'h00);
    push_item(MODE_CLR, 8'hFF);
    push_item(MODE_TXT, 8'h00);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      if (phase == 2) add_search_session(1'b1);
      while (queued_count < PHASE_ITEMS * (phase + 1)) add_search_session(1'b0);
      while (pending_items.size() > 0) @(posedge clk);
    end

    while (in_valid || expected_starts.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
